// ===== hdl/vrss_pkg.sv =====
// ----------------------------------------------------------------------------
// vrss_pkg
// shared widths, request and status codes and payload types of the
// virtual range segment splitter
// ----------------------------------------------------------------------------
package vrss_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int PIECE_CAP        = 64;

    localparam int TYPE_W = 2;
    localparam int LEN_W  = 40;
    localparam int ADDR_W = 48;
    localparam int STAT_W = 3;
    localparam int SIDX_W = 6;

    // request codes
    localparam logic [TYPE_W-1:0] REQ_CLEAR   = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_APPEND  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_RESOLVE = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_RSVD    = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_SEGMENT    = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_OVERLAP = 3'd1;
    localparam logic [STAT_W-1:0] ST_ACK        = 3'd2;
    localparam logic [STAT_W-1:0] ST_TABLE_FULL = 3'd3;
    localparam logic [STAT_W-1:0] ST_ZERO_SKIP  = 3'd4;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SIDX_W-1:0] seg_index;
        logic [LEN_W-1:0]  inner_offset;
        logic [LEN_W-1:0]  piece_bytes;
        logic [ADDR_W-1:0] total_bytes;
        logic              last_piece;
    } t_rsp;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  size;
    } t_seg_entry;

endpackage

// ===== hdl/vrss_if.sv =====
// ----------------------------------------------------------------------------
// vrss request and result channels
// valid/ready channels carrying the request and result payloads
// ----------------------------------------------------------------------------
interface vrss_req_if;
    logic                      valid;
    logic                      ready;
    logic [vrss_pkg::TYPE_W-1:0] req_type;
    logic [vrss_pkg::LEN_W-1:0]  seg_length;
    logic [vrss_pkg::ADDR_W-1:0] range_first;
    logic [vrss_pkg::ADDR_W-1:0] range_final;

    modport source (output valid, req_type, seg_length, range_first, range_final,
                    input ready);
    modport sink   (input valid, req_type, seg_length, range_first, range_final,
                    output ready);
endinterface

interface vrss_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [vrss_pkg::STAT_W-1:0] status;
    logic [vrss_pkg::SIDX_W-1:0] seg_index;
    logic [vrss_pkg::LEN_W-1:0]  inner_offset;
    logic [vrss_pkg::LEN_W-1:0]  piece_bytes;
    logic [vrss_pkg::ADDR_W-1:0] total_bytes;
    logic                        last_piece;

    modport source (output valid, status, seg_index, inner_offset, piece_bytes,
                    total_bytes, last_piece, input ready);
    modport sink   (input valid, status, seg_index, inner_offset, piece_bytes,
                    total_bytes, last_piece, output ready);
endinterface

// ===== hdl/vrss_seg_mem.sv =====
// ----------------------------------------------------------------------------
// vrss_seg_mem
// segment table: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module vrss_seg_mem #(
    parameter int DEPTH = vrss_pkg::MAX_SEGMENTS_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [IDX_W-1:0]     i_wr_addr,
    input  vrss_pkg::t_seg_entry i_wr_data,
    input  logic                 i_rd_en,
    input  logic [IDX_W-1:0]     i_rd_addr,
    output vrss_pkg::t_seg_entry o_rd_data
);

    vrss_pkg::t_seg_entry r_mem [DEPTH];
    vrss_pkg::t_seg_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/vrss_out_buf.sv =====
// ----------------------------------------------------------------------------
// vrss_out_buf
// one-entry result register between the engine and the result channel
// ----------------------------------------------------------------------------
module vrss_out_buf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vrss_pkg::t_rsp i_rsp,
    output logic           o_push_ready,
    vrss_rsp_if.source     o_rsp
);

    logic           r_valid;
    vrss_pkg::t_rsp r_rsp;

    assign o_push_ready = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_push_ready) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push_ready && i_push) begin
            r_rsp <= i_rsp;
        end
    end

    assign o_rsp.valid        = r_valid;
    assign o_rsp.status       = r_rsp.status;
    assign o_rsp.seg_index    = r_rsp.seg_index;
    assign o_rsp.inner_offset = r_rsp.inner_offset;
    assign o_rsp.piece_bytes  = r_rsp.piece_bytes;
    assign o_rsp.total_bytes  = r_rsp.total_bytes;
    assign o_rsp.last_piece   = r_rsp.last_piece;

endmodule

// ===== hdl/vrss_engine.sv =====
// ----------------------------------------------------------------------------
// vrss_engine
// request sequencer: table updates, binary search and forward walk
// ----------------------------------------------------------------------------
module vrss_engine #(
    parameter int MAX_SEGMENTS = vrss_pkg::MAX_SEGMENTS_DEF,
    parameter int IDX_W        = $clog2(MAX_SEGMENTS),
    parameter int CNT_W        = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    vrss_req_if.sink             i_req,
    output logic                 o_wr_en,
    output logic [IDX_W-1:0]     o_wr_addr,
    output vrss_pkg::t_seg_entry o_wr_data,
    output logic                 o_rd_en,
    output logic [IDX_W-1:0]     o_rd_addr,
    input  vrss_pkg::t_seg_entry i_rd_data,
    output logic                 o_push,
    output vrss_pkg::t_rsp       o_push_rsp,
    input  logic                 i_push_ready
);

    localparam int ADDR_W = vrss_pkg::ADDR_W;
    localparam int LEN_W  = vrss_pkg::LEN_W;
    localparam int N_W    = $clog2(vrss_pkg::PIECE_CAP);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_SRCH     = 3'd2;
    localparam logic [2:0] S_SRCH_CMP = 3'd3;
    localparam logic [2:0] S_WALK_RD  = 3'd4;
    localparam logic [2:0] S_WALK_END = 3'd5;
    localparam logic [2:0] S_WALK_CHK = 3'd6;
    localparam logic [2:0] S_WALK_OUT = 3'd7;

    logic [2:0]                  r_state, n_state;
    logic [CNT_W-1:0]            r_count, n_count;
    logic [ADDR_W-1:0]           r_total, n_total;

    // latched request
    logic [vrss_pkg::TYPE_W-1:0] r_type;
    logic [LEN_W-1:0]            r_len;
    logic [ADDR_W-1:0]           r_first, r_final;

    // search and walk
    logic [CNT_W-1:0]            r_lo, n_lo, r_hi, n_hi;
    logic [IDX_W-1:0]            r_mid, n_mid, r_idx, n_idx;
    logic [N_W-1:0]              r_n, n_n;
    logic [ADDR_W-1:0]           r_base, n_base, r_end, n_end;
    logic [ADDR_W-1:0]           r_s, n_s, r_t, n_t;
    logic                        r_miss, n_miss, r_last, n_last;

    logic [ADDR_W:0]             append_sum;
    logic [CNT_W:0]              lohi_sum;
    logic [CNT_W-1:0]            mid_wide;
    logic [IDX_W+vrss_pkg::SIDX_W-1:0] idx_ext;
    logic [ADDR_W-1:0]           piece_off, piece_len;

    assign append_sum = {1'b0, r_total} + {{(ADDR_W-LEN_W+1){1'b0}}, r_len};
    assign lohi_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid_wide   = lohi_sum[CNT_W:1];
    assign idx_ext    = {{vrss_pkg::SIDX_W{1'b0}}, r_idx};
    assign piece_off  = r_s - r_base;
    assign piece_len  = r_t - r_s + ADDR_W'(1);

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_total    = r_total;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_mid      = r_mid;
        n_idx      = r_idx;
        n_n        = r_n;
        n_base     = r_base;
        n_end      = r_end;
        n_s        = r_s;
        n_t        = r_t;
        n_miss     = r_miss;
        n_last     = r_last;
        o_wr_en    = 1'b0;
        o_wr_addr  = r_count[IDX_W-1:0];
        o_wr_data  = '{base: r_total, size: r_len};
        o_rd_en    = 1'b0;
        o_rd_addr  = r_idx;
        o_push     = 1'b0;
        o_push_rsp = '0;
        o_push_rsp.total_bytes = r_total;
        o_push_rsp.last_piece  = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (r_type)
                    vrss_pkg::REQ_CLEAR: begin
                        if (i_push_ready) begin
                            o_push  = 1'b1;
                            o_push_rsp.status      = vrss_pkg::ST_ACK;
                            o_push_rsp.total_bytes = '0;
                            n_count = '0;
                            n_total = '0;
                            n_state = S_IDLE;
                        end
                    end
                    vrss_pkg::REQ_APPEND: begin
                        if (i_push_ready) begin
                            o_push  = 1'b1;
                            n_state = S_IDLE;
                            if (r_len == '0) begin
                                o_push_rsp.status = vrss_pkg::ST_ZERO_SKIP;
                            end else if (r_count == CNT_W'(MAX_SEGMENTS) || append_sum[ADDR_W]) begin
                                o_push_rsp.status = vrss_pkg::ST_TABLE_FULL;
                            end else begin
                                o_wr_en = 1'b1;
                                o_push_rsp.status      = vrss_pkg::ST_ACK;
                                o_push_rsp.total_bytes = append_sum[ADDR_W-1:0];
                                n_count = r_count + CNT_W'(1);
                                n_total = append_sum[ADDR_W-1:0];
                            end
                        end
                    end
                    vrss_pkg::REQ_RESOLVE: begin
                        if (r_count == '0 || r_first > r_final) begin
                            if (i_push_ready) begin
                                o_push  = 1'b1;
                                o_push_rsp.status = vrss_pkg::ST_NO_OVERLAP;
                                n_state = S_IDLE;
                            end
                        end else begin
                            n_lo    = '0;
                            n_hi    = r_count;
                            n_n     = '0;
                            n_state = S_SRCH;
                        end
                    end
                    default: begin
                        if (i_push_ready) begin
                            o_push  = 1'b1;
                            o_push_rsp.status = vrss_pkg::ST_ACK;
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = mid_wide[IDX_W-1:0];
                    n_mid     = mid_wide[IDX_W-1:0];
                    n_state   = S_SRCH_CMP;
                end else begin
                    // segment just below the first base above range_first
                    n_idx   = (r_lo == '0) ? '0 : IDX_W'(r_lo - CNT_W'(1));
                    n_state = S_WALK_RD;
                end
            end
            S_SRCH_CMP: begin
                if (r_first < i_rd_data.base) begin
                    n_hi = CNT_W'(r_mid);
                end else begin
                    n_lo = CNT_W'(r_mid) + CNT_W'(1);
                end
                n_state = S_SRCH;
            end
            S_WALK_RD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = r_idx;
                n_state   = S_WALK_END;
            end
            S_WALK_END: begin
                n_base  = i_rd_data.base;
                n_end   = i_rd_data.base + {{(ADDR_W-LEN_W){1'b0}}, i_rd_data.size}
                          - ADDR_W'(1);
                n_state = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                // segments are contiguous, so only the first one read can miss
                n_miss  = r_end < r_first;
                n_s     = (r_first > r_base) ? r_first : r_base;
                n_t     = (r_final < r_end) ? r_final : r_end;
                n_last  = (r_final <= r_end)
                          || ((CNT_W'(r_idx) + CNT_W'(1)) == r_count)
                          || (r_n == N_W'(vrss_pkg::PIECE_CAP - 1));
                n_state = S_WALK_OUT;
            end
            S_WALK_OUT: begin
                if (i_push_ready) begin
                    o_push = 1'b1;
                    if (r_miss) begin
                        o_push_rsp.status = vrss_pkg::ST_NO_OVERLAP;
                        n_state = S_IDLE;
                    end else begin
                        o_push_rsp.status       = vrss_pkg::ST_SEGMENT;
                        o_push_rsp.seg_index    = idx_ext[vrss_pkg::SIDX_W-1:0];
                        o_push_rsp.inner_offset = piece_off[LEN_W-1:0];
                        o_push_rsp.piece_bytes  = piece_len[LEN_W-1:0];
                        o_push_rsp.last_piece   = r_last;
                        if (r_last) begin
                            n_state = S_IDLE;
                        end else begin
                            n_idx   = r_idx + IDX_W'(1);
                            n_n     = r_n + N_W'(1);
                            n_state = S_WALK_RD;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) begin
            r_type  <= i_req.req_type;
            r_len   <= i_req.seg_length;
            r_first <= i_req.range_first;
            r_final <= i_req.range_final;
        end
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
        r_idx  <= n_idx;
        r_n    <= n_n;
        r_base <= n_base;
        r_end  <= n_end;
        r_s    <= n_s;
        r_t    <= n_t;
        r_miss <= n_miss;
        r_last <= n_last;
    end

endmodule

// ===== hdl/virtual_range_segment_splitter.sv =====
// ----------------------------------------------------------------------------
// virtual_range_segment_splitter
// segment table over one virtual byte space; resolves byte ranges into
// per-segment pieces
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake        payload
//  -------  ---  ---------------  ------------------------------------------
//  i_req    in   valid / ready    req_type, seg_length, range_first,
//                                 range_final
//  o_rsp    out  valid / ready    status, seg_index, inner_offset,
//                                 piece_bytes, total_bytes, last_piece
//
//  one request at a time: clear, append, reserved and trivially empty resolves
//  go from decode straight to their result; a searching resolve runs a binary
//  search, then takes each piece through read, end, check and result in turn
//  i_rst_n is synchronous and active low; count and total clear, contents stay
//  undefined until appended; a stalled o_rsp holds the engine at its next result
//  a new request is taken while the last result of the previous one waits in o_rsp
//
module virtual_range_segment_splitter #(
    parameter int MAX_SEGMENTS = vrss_pkg::MAX_SEGMENTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vrss_req_if.sink   i_req,
    vrss_rsp_if.source o_rsp
);

    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    // segment table port signals
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    vrss_pkg::t_seg_entry wr_data;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    vrss_pkg::t_seg_entry rd_data;

    // engine to result register
    logic                 push;
    vrss_pkg::t_rsp       push_rsp;
    logic                 push_ready;

    // sequencer: decodes each request, updates count and total, runs the
    // search and walk against the table
    vrss_engine #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_push       (push),
        .o_push_rsp   (push_rsp),
        .i_push_ready (push_ready)
    );

    // base and size of every segment, registered read data
    vrss_seg_mem #(
        .DEPTH     (MAX_SEGMENTS),
        .IDX_W     (IDX_W)
    ) u_seg_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // result register decouples the engine from the result sink
    vrss_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_rsp        (push_rsp),
        .o_push_ready (push_ready),
        .o_rsp        (o_rsp)
    );

endmodule

// ===== hdl/vrss_checker.sv =====
// ----------------------------------------------------------------------------
// vrss_checker
// port-level checks of request/result pairing and result payloads
// ----------------------------------------------------------------------------
module vrss_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_req_valid,
    input logic                        i_req_ready,
    input logic                        i_rsp_valid,
    input logic                        i_rsp_ready,
    input logic [vrss_pkg::STAT_W-1:0] i_status,
    input logic [vrss_pkg::SIDX_W-1:0] i_seg_index,
    input logic [vrss_pkg::LEN_W-1:0]  i_inner_offset,
    input logic [vrss_pkg::LEN_W-1:0]  i_piece_bytes,
    input logic [vrss_pkg::ADDR_W-1:0] i_total_bytes,
    input logic                        i_last_piece
);

    logic       req_acc, rsp_done;
    logic [1:0] r_open, n_open;

    assign req_acc  = i_req_valid && i_req_ready;
    assign rsp_done = i_rsp_valid && i_rsp_ready && i_last_piece;

    // requests whose last result has not been delivered yet
    always_comb begin
        n_open = r_open;
        if (req_acc && !rsp_done) begin
            n_open = r_open + 2'd1;
        end else if (!req_acc && rsp_done) begin
            n_open = r_open - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= n_open;
        end
    end

    a_open_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |-> r_open <= 2'd1)
        else $error("request taken with two requests still open");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_open != 2'd0)
        else $error("result shown with no open request");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_status != vrss_pkg::ST_SEGMENT) |->
            (i_last_piece && i_seg_index == '0 && i_inner_offset == '0
             && i_piece_bytes == '0))
        else $error("non-segment result with piece fields set or not last");

    a_piece_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_status == vrss_pkg::ST_SEGMENT) |-> i_piece_bytes != '0)
        else $error("segment piece of zero bytes");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_status) && $stable(i_total_bytes)
             && $stable(i_piece_bytes) && $stable(i_last_piece)))
        else $error("stalled result changed");

endmodule

bind virtual_range_segment_splitter vrss_checker u_vrss_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_status       (o_rsp.status),
    .i_seg_index    (o_rsp.seg_index),
    .i_inner_offset (o_rsp.inner_offset),
    .i_piece_bytes  (o_rsp.piece_bytes),
    .i_total_bytes  (o_rsp.total_bytes),
    .i_last_piece   (o_rsp.last_piece)
);
